// ----- hw/rtl/adrc_pkg.sv -----
// Shared constants, register codes and beat types of the ADRC observer controller.
package adrc_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DT_WIDTH    = 32;
  localparam int DT_FRAC     = 24;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_L1     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_L2     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_L3     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KP     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KD     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_B0     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_B0_INV = 3'd6;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] reference;
    logic signed [DATA_WIDTH-1:0] measurement;
    logic        [DT_WIDTH-1:0]   time_step;
  } item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] command;
    logic                         saturated;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic                  use_dt;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DT_WIDTH-1:0]   dt;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic                  clip;
    logic [DATA_WIDTH-1:0] value;
  } mul_rsp_t;

endpackage

// ----- hw/rtl/adrc_ser_mul.sv -----
// Bit-serial saturating fixed-point multiplier with round-to-nearest, ties away from zero.
module adrc_ser_mul #(
  parameter int FRAC_BITS = adrc_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  adrc_pkg::mul_req_t req,
  output adrc_pkg::mul_rsp_t rsp
);

  localparam int DW  = adrc_pkg::DATA_WIDTH;
  localparam int DTW = adrc_pkg::DT_WIDTH;
  localparam int DTF = adrc_pkg::DT_FRAC;
  localparam int BW  = (DW > DTW) ? DW : DTW;
  localparam int PW  = DW + BW;
  localparam int CW  = $clog2(BW);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_RUN  = 3'd1;
  localparam logic [2:0] M_RND  = 3'd2;
  localparam logic [2:0] M_NEG  = 3'd3;
  localparam logic [2:0] M_DONE = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [DW-1:0] ua;
  logic [DW-1:0] hi;
  logic [BW-1:0] lo;
  logic          neg;
  logic          use_dt;
  logic [DW-1:0] mag;
  logic          clip;
  logic [DW-1:0] value;

  logic [DW-1:0] a_mag;
  logic [DW-1:0] b_mag;
  logic [DW:0]   sum;
  logic [PW-1:0] product;
  logic [PW-1:0] q;
  logic          rb;
  logic          ovf_hi;
  logic [DW:0]   inc;
  logic [DW:0]   limit;
  logic          clip_next;
  logic [DW-1:0] mag_next;

  always_comb begin
    a_mag     = req.a[DW-1] ? (~req.a + DW'(1)) : req.a;
    b_mag     = req.b[DW-1] ? (~req.b + DW'(1)) : req.b;
    sum       = {1'b0, hi} + (lo[0] ? {1'b0, ua} : {(DW+1){1'b0}});
    product   = {hi, lo};
    q         = use_dt ? (product >> DTF) : (product >> FRAC_BITS);
    rb        = use_dt ? product[DTF-1] : product[FRAC_BITS-1];
    ovf_hi    = |q[PW-1:DW];
    inc       = {1'b0, q[DW-1:0]} + (DW+1)'(rb);
    limit     = {2'b00, {(DW-1){1'b1}}} + (DW+1)'(neg);
    clip_next = ovf_hi || (inc > limit);
    mag_next  = clip_next ? limit[DW-1:0] : inc[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        M_IDLE: begin
          if (req.start) begin
            state <= M_RUN;
            cnt   <= CW'(BW - 1);
          end
        end
        M_RUN: begin
          if (cnt == '0) begin
            state <= M_RND;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        M_RND:   state <= M_NEG;
        M_NEG:   state <= M_DONE;
        M_DONE:  state <= M_IDLE;
        default: state <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (req.start) begin
          ua     <= a_mag;
          hi     <= '0;
          lo     <= req.use_dt ? BW'(req.dt) : BW'(b_mag);
          neg    <= req.a[DW-1] ^ (!req.use_dt && req.b[DW-1]);
          use_dt <= req.use_dt;
        end
      end
      M_RUN: begin
        hi <= sum[DW:1];
        lo <= {sum[0], lo[BW-1:1]};
      end
      M_RND: begin
        mag  <= mag_next;
        clip <= clip_next;
      end
      M_NEG: begin
        value <= neg ? (~mag + DW'(1)) : mag;
      end
      default: begin
      end
    endcase
  end

  assign rsp.done  = (state == M_DONE);
  assign rsp.clip  = clip;
  assign rsp.value = value;

endmodule

// ----- hw/rtl/adrc_eso_controller_step.sv -----
// Linear ADRC controller step with a third-order extended state observer, top level.
// One item is in work at a time; the input is stalled from the accepted beat until the
// result beat has been issued and the controller is idle again.
// The ten products of each item share one bit-serial multiplier, which retires one
// multiplier bit per cycle.
// Synchronous reset clears the estimates, the previous command and the gains; b0 and its
// reciprocal reset to 1.0.
module adrc_eso_controller_step #(
  parameter int FRAC_BITS = adrc_pkg::FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  adrc_pkg::item_t                      item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output adrc_pkg::result_t                    result,
  input  logic                                 cfg_write,
  input  logic [adrc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [adrc_pkg::DATA_WIDTH-1:0]      cfg_data
);

  localparam int DW  = adrc_pkg::DATA_WIDTH;
  localparam int DTW = adrc_pkg::DT_WIDTH;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ERR  = 4'd1;
  localparam logic [3:0] ST_L1   = 4'd2;
  localparam logic [3:0] ST_L2   = 4'd3;
  localparam logic [3:0] ST_B0   = 4'd4;
  localparam logic [3:0] ST_L3   = 4'd5;
  localparam logic [3:0] ST_I1   = 4'd6;
  localparam logic [3:0] ST_I2   = 4'd7;
  localparam logic [3:0] ST_I3   = 4'd8;
  localparam logic [3:0] ST_DIF  = 4'd9;
  localparam logic [3:0] ST_KP   = 4'd10;
  localparam logic [3:0] ST_KD   = 4'd11;
  localparam logic [3:0] ST_Z3   = 4'd12;
  localparam logic [3:0] ST_RC   = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  logic [3:0]     state;
  logic           issued;
  logic           clipped;

  logic [DW-1:0]  l1;
  logic [DW-1:0]  l2;
  logic [DW-1:0]  l3;
  logic [DW-1:0]  kp;
  logic [DW-1:0]  kd;
  logic [DW-1:0]  b0;
  logic [DW-1:0]  b0_recip;

  logic [DW-1:0]  z1;
  logic [DW-1:0]  z2;
  logic [DW-1:0]  z3;
  logic [DW-1:0]  u_prev;

  logic [DW-1:0]  ref_val;
  logic [DW-1:0]  meas;
  logic [DTW-1:0] dt;
  logic [DW-1:0]  err;
  logic [DW-1:0]  d1;
  logic [DW-1:0]  d2;
  logic [DW-1:0]  d3;
  logic [DW-1:0]  v;

  logic [DW-1:0]  add_a;
  logic [DW-1:0]  add_b;
  logic           add_sub;
  logic [DW:0]    add_sum;
  logic           add_ovf;
  logic [DW-1:0]  add_res;
  logic           is_mul;

  adrc_pkg::mul_req_t mreq;
  adrc_pkg::mul_rsp_t mrsp;

  adrc_ser_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .req(mreq),
    .rsp(mrsp)
  );

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      ST_ERR: begin
        add_a   = meas;
        add_b   = z1;
        add_sub = 1'b1;
      end
      ST_L1: begin
        add_a = z2;
        add_b = mrsp.value;
      end
      ST_L2: begin
        add_a = z3;
        add_b = mrsp.value;
      end
      ST_B0: begin
        add_a = d2;
        add_b = mrsp.value;
      end
      ST_I1: begin
        add_a = z1;
        add_b = mrsp.value;
      end
      ST_I2: begin
        add_a = z2;
        add_b = mrsp.value;
      end
      ST_I3: begin
        add_a = z3;
        add_b = mrsp.value;
      end
      ST_DIF: begin
        add_a   = ref_val;
        add_b   = z1;
        add_sub = 1'b1;
      end
      ST_KD: begin
        add_a   = v;
        add_b   = mrsp.value;
        add_sub = 1'b1;
      end
      ST_Z3: begin
        add_a   = v;
        add_b   = z3;
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    add_sum = add_sub ? ({add_a[DW-1], add_a} - {add_b[DW-1], add_b})
                      : ({add_a[DW-1], add_a} + {add_b[DW-1], add_b});
    add_ovf = add_sum[DW] ^ add_sum[DW-1];
    add_res = add_ovf ? {add_sum[DW], {(DW-1){~add_sum[DW]}}} : add_sum[DW-1:0];
  end

  always_comb begin
    is_mul      = 1'b1;
    mreq.use_dt = 1'b0;
    mreq.a      = '0;
    mreq.b      = '0;
    mreq.dt     = dt;
    case (state)
      ST_L1: begin
        mreq.a = l1;
        mreq.b = err;
      end
      ST_L2: begin
        mreq.a = l2;
        mreq.b = err;
      end
      ST_B0: begin
        mreq.a = b0;
        mreq.b = u_prev;
      end
      ST_L3: begin
        mreq.a = l3;
        mreq.b = err;
      end
      ST_I1: begin
        mreq.a      = d1;
        mreq.use_dt = 1'b1;
      end
      ST_I2: begin
        mreq.a      = d2;
        mreq.use_dt = 1'b1;
      end
      ST_I3: begin
        mreq.a      = d3;
        mreq.use_dt = 1'b1;
      end
      ST_KP: begin
        mreq.a = kp;
        mreq.b = err;
      end
      ST_KD: begin
        mreq.a = kd;
        mreq.b = z2;
      end
      ST_RC: begin
        mreq.a = v;
        mreq.b = b0_recip;
      end
      default: is_mul = 1'b0;
    endcase
    mreq.start = is_mul && !issued;
  end

  assign item_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issued       <= 1'b0;
      clipped      <= 1'b0;
      result_valid <= 1'b0;
      l1           <= '0;
      l2           <= '0;
      l3           <= '0;
      kp           <= '0;
      kd           <= '0;
      b0           <= DW'(1) << FRAC_BITS;
      b0_recip     <= DW'(1) << FRAC_BITS;
      z1           <= '0;
      z2           <= '0;
      z3           <= '0;
      u_prev       <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          adrc_pkg::REG_L1:     l1       <= cfg_data;
          adrc_pkg::REG_L2:     l2       <= cfg_data;
          adrc_pkg::REG_L3:     l3       <= cfg_data;
          adrc_pkg::REG_KP:     kp       <= cfg_data;
          adrc_pkg::REG_KD:     kd       <= cfg_data;
          adrc_pkg::REG_B0:     b0       <= cfg_data;
          adrc_pkg::REG_B0_INV: b0_recip <= cfg_data;
          default: begin
          end
        endcase
      end

      if (state == ST_OUT && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (mreq.start) begin
        issued <= 1'b1;
      end else if (mrsp.done) begin
        issued <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            clipped <= 1'b0;
            state   <= ST_ERR;
          end
        end
        ST_ERR: begin
          clipped <= clipped | add_ovf;
          state   <= ST_L1;
        end
        ST_L1: begin
          if (mrsp.done) begin
            clipped <= clipped | add_ovf | mrsp.clip;
            state   <= ST_L2;
          end
        end
        ST_L2: begin
          if (mrsp.done) begin
            clipped <= clipped | add_ovf | mrsp.clip;
            state   <= ST_B0;
          end
        end
        ST_B0: begin
          if (mrsp.done) begin
            clipped <= clipped | add_ovf | mrsp.clip;
            state   <= ST_L3;
          end
        end
        ST_L3: begin
          if (mrsp.done) begin
            clipped <= clipped | mrsp.clip;
            state   <= ST_I1;
          end
        end
        ST_I1: begin
          if (mrsp.done) begin
            z1      <= add_res;
            clipped <= clipped | add_ovf | mrsp.clip;
            state   <= ST_I2;
          end
        end
        ST_I2: begin
          if (mrsp.done) begin
            z2      <= add_res;
            clipped <= clipped | add_ovf | mrsp.clip;
            state   <= ST_I3;
          end
        end
        ST_I3: begin
          if (mrsp.done) begin
            z3      <= add_res;
            clipped <= clipped | add_ovf | mrsp.clip;
            state   <= ST_DIF;
          end
        end
        ST_DIF: begin
          clipped <= clipped | add_ovf;
          state   <= ST_KP;
        end
        ST_KP: begin
          if (mrsp.done) begin
            clipped <= clipped | mrsp.clip;
            state   <= ST_KD;
          end
        end
        ST_KD: begin
          if (mrsp.done) begin
            clipped <= clipped | add_ovf | mrsp.clip;
            state   <= ST_Z3;
          end
        end
        ST_Z3: begin
          clipped <= clipped | add_ovf;
          state   <= ST_RC;
        end
        ST_RC: begin
          if (mrsp.done) begin
            u_prev  <= mrsp.value;
            clipped <= clipped | mrsp.clip;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!result_valid || !result_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          ref_val <= item.reference;
          meas    <= item.measurement;
          dt      <= item.time_step;
        end
      end
      ST_ERR: err <= add_res;
      ST_L1: begin
        if (mrsp.done) begin
          d1 <= add_res;
        end
      end
      ST_L2: begin
        if (mrsp.done) begin
          d2 <= add_res;
        end
      end
      ST_B0: begin
        if (mrsp.done) begin
          d2 <= add_res;
        end
      end
      ST_L3: begin
        if (mrsp.done) begin
          d3 <= mrsp.value;
        end
      end
      ST_DIF: err <= add_res;
      ST_KP: begin
        if (mrsp.done) begin
          v <= mrsp.value;
        end
      end
      ST_KD: begin
        if (mrsp.done) begin
          v <= add_res;
        end
      end
      ST_Z3: v <= add_res;
      ST_OUT: begin
        if (!result_valid || !result_stall) begin
          result.command   <= u_prev;
          result.saturated <= clipped;
        end
      end
      default: begin
      end
    endcase
  end

  a_done_requested: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> issued)
    else $error("Multiplier finished a product that was never started.");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_OUT)
    else $error("Result beat raised outside the output step.");

  a_flag_cleared: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> !clipped)
    else $error("Saturation flag not cleared for a new item.");

endmodule
